### sv/dtvg_pkg.sv
package dtvg_pkg;

	localparam int GENE_W        = 32;
	localparam int SCALE_W       = 18;
	localparam int THR_W         = 17;
	localparam int DRAW_W        = 16;
	localparam int COUNT_W       = 9;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 18;
	localparam int MAX_GENES_DEF = 256;

	localparam logic [SCALE_W-1:0] SCALE_F_RST = 18'd32768;
	localparam logic [SCALE_W-1:0] SCALE_K_RST = 18'd32768;
	localparam logic [THR_W-1:0]   THR_RST     = 17'd58982;

	typedef enum logic [1:0] {
		STRAT_RAND1_BIN    = 2'd0,
		STRAT_CUR2RAND     = 2'd1,
		STRAT_RAND1_EXP    = 2'd2,
		STRAT_CUR2RAND_BIN = 2'd3
	} strategy_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STRATEGY  = 2'd0,
		REG_SCALE_F   = 2'd1,
		REG_SCALE_K   = 2'd2,
		REG_THRESHOLD = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [GENE_W-1:0] target_gene;
		logic signed [GENE_W-1:0] donor_one;
		logic signed [GENE_W-1:0] donor_two;
		logic signed [GENE_W-1:0] base_gene;
		logic signed [GENE_W-1:0] upper_bound;
		logic signed [GENE_W-1:0] lower_bound;
		logic                     upper_enable;
		logic                     lower_enable;
		logic [DRAW_W-1:0]        random_draw;
		logic                     first_gene;
		logic                     last_gene;
	} item_t;

	typedef struct packed {
		logic signed [GENE_W-1:0] trial_value;
		logic                     took_mutant;
		logic [COUNT_W-1:0]       mutation_count;
		logic                     vector_done;
	} result_t;

endpackage

### sv/de_trial_vector_generator_top.sv
// Differential-evolution trial vector generator, one gene per transaction.
// Item channel (item_valid/item_stall/item): genes of one vector in processing
// order, start gene flagged by first_gene, final gene by last_gene.
// Result channel (result_valid/result_stall/result): one trial gene per item,
// in order; mutation_count and vector_done are set on the last gene only.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): cfg_ready is always
// high; write registers only while no gene is in flight.
// Pipeline: input register, product register (both multipliers in parallel),
// result register. A result reaches the result register after its item has
// passed the input and product registers. Throughput is one gene per cycle
// while result_stall is low; the tallies update once per gene as it leaves
// stage one. A stalled result holds; the pipeline keeps filling behind it and
// item_stall rises only once every stage is full.
// Reset clears the pipeline, the tallies and the exponential latch and loads
// strategy 0, F = K = 0.5 and threshold 58982.
module de_trial_vector_generator_top
	import dtvg_pkg::*;
#(
	parameter int MAX_GENES = MAX_GENES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CW = $clog2(MAX_GENES + 2);
	localparam logic [CW-1:0] GENE_MAX = CW'(MAX_GENES);
	localparam logic [CW-1:0] MUT_MAX  = CW'(MAX_GENES + 1);
	localparam logic [CW-1:0] ONE      = CW'(1);

	strategy_t          strategy_q;
	logic [SCALE_W-1:0] scale_f_q, scale_k_q;
	logic [THR_W-1:0]   thr_q;

	logic          exp_latched_q;
	logic [CW-1:0] mutate_tally_q, gene_tally_q;

	logic  v1_q, v2_q, result_valid_q;
	logic  adv1, adv2, adv3;
	item_t item_s1;

	logic signed [GENE_W-1:0] tgt_s2, base_s2, ub_s2, lb_s2;
	logic                     ue_s2, le_s2, cur_s2, use_s2, last_s2;
	logic signed [35:0]       pf_s2, pk_s2;
	logic [COUNT_W-1:0]       count_s2;
	result_t                  result_q;

	// stage one
	logic signed [32:0] dif_f, dif_k;
	logic signed [51:0] prod_f, prod_k;
	logic               coin, counted, use_mut, lat0, lat1, cur;
	logic [CW-1:0]      mt0, mt1, gt0, gt1, cnt;

	// stage two
	logic signed [37:0]       sum;
	logic signed [GENE_W-1:0] sat, clu, mut;

	assign cfg_ready    = 1'b1;
	assign adv3         = !result_valid_q || !result_stall;
	assign adv2         = !v2_q || adv3;
	assign adv1         = !v1_q || adv2;
	assign item_stall   = !adv1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		dif_f  = $signed({item_s1.donor_one[GENE_W-1], item_s1.donor_one}) -
			$signed({item_s1.donor_two[GENE_W-1], item_s1.donor_two});
		dif_k  = $signed({item_s1.base_gene[GENE_W-1], item_s1.base_gene}) -
			$signed({item_s1.target_gene[GENE_W-1], item_s1.target_gene});
		prod_f = dif_f * $signed({1'b0, scale_f_q});
		prod_k = dif_k * $signed({1'b0, scale_k_q});

		coin = {1'b0, item_s1.random_draw} < thr_q;
		cur  = (strategy_q == STRAT_CUR2RAND) || (strategy_q == STRAT_CUR2RAND_BIN);
		lat0 = item_s1.first_gene ? 1'b0 : exp_latched_q;
		mt0  = item_s1.first_gene ? ONE : mutate_tally_q;
		gt0  = item_s1.first_gene ? '0 : gene_tally_q;
		lat1 = lat0;
		case (strategy_q)
			STRAT_CUR2RAND: begin
				use_mut = 1'b1;
				counted = 1'b0;
			end
			STRAT_RAND1_EXP: begin
				lat1    = lat0 || coin;
				counted = lat1;
				use_mut = lat1 || item_s1.first_gene;
			end
			default: begin
				counted = coin;
				use_mut = coin || item_s1.first_gene;
			end
		endcase
		mt1 = (counted && mt0 < MUT_MAX) ? mt0 + ONE : mt0;
		gt1 = (gt0 < GENE_MAX) ? gt0 + ONE : gt0;
		cnt = (strategy_q == STRAT_CUR2RAND) ? gt1 : mt1;
	end

	always_comb begin
		sum = 38'(cur_s2 ? tgt_s2 : base_s2) + (cur_s2 ? 38'(pk_s2) : 38'sd0) + 38'(pf_s2);
		if (sum > 38'sd2147483647)
			sat = 32'sh7FFFFFFF;
		else if (sum < -38'sd2147483648)
			sat = 32'sh80000000;
		else
			sat = sum[GENE_W-1:0];
		clu = (ue_s2 && sat > ub_s2) ? ub_s2 : sat;
		mut = (le_s2 && clu < lb_s2) ? lb_s2 : clu;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strategy_q     <= STRAT_RAND1_BIN;
			scale_f_q      <= SCALE_F_RST;
			scale_k_q      <= SCALE_K_RST;
			thr_q          <= THR_RST;
			exp_latched_q  <= 1'b0;
			mutate_tally_q <= '0;
			gene_tally_q   <= '0;
			v1_q           <= 1'b0;
			v2_q           <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_STRATEGY:  strategy_q <= strategy_t'(cfg_data[1:0]);
					REG_SCALE_F:   scale_f_q  <= cfg_data[SCALE_W-1:0];
					REG_SCALE_K:   scale_k_q  <= cfg_data[SCALE_W-1:0];
					REG_THRESHOLD: thr_q      <= cfg_data[THR_W-1:0];
					default: ;
				endcase
			end
			if (v1_q && adv2) begin
				exp_latched_q  <= lat1;
				mutate_tally_q <= mt1;
				gene_tally_q   <= gt1;
			end
			if (adv1)
				v1_q <= item_valid;
			if (adv2)
				v2_q <= v1_q;
			if (adv3)
				result_valid_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && item_valid)
			item_s1 <= item;
		if (adv2 && v1_q) begin
			tgt_s2   <= item_s1.target_gene;
			base_s2  <= item_s1.base_gene;
			ub_s2    <= item_s1.upper_bound;
			lb_s2    <= item_s1.lower_bound;
			ue_s2    <= item_s1.upper_enable;
			le_s2    <= item_s1.lower_enable;
			last_s2  <= item_s1.last_gene;
			cur_s2   <= cur;
			use_s2   <= use_mut;
			pf_s2    <= prod_f[51:16];
			pk_s2    <= prod_k[51:16];
			count_s2 <= item_s1.last_gene ? COUNT_W'(cnt) : '0;
		end
		if (adv3 && v2_q) begin
			result_q.trial_value    <= use_s2 ? mut : tgt_s2;
			result_q.took_mutant    <= use_s2;
			result_q.mutation_count <= count_s2;
			result_q.vector_done    <= last_s2;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.vector_done |-> result.mutation_count == '0)
		else $error("mutation count set on a gene that is not last");

	a_mut_tally_max: assert property (@(posedge clk) disable iff (!arst_n)
		mutate_tally_q <= MUT_MAX)
		else $error("mutate tally above limit");

	a_gene_tally_max: assert property (@(posedge clk) disable iff (!arst_n)
		gene_tally_q <= GENE_MAX)
		else $error("gene tally above limit");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result lost or changed");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q && v2_q && result_valid && result_stall |-> item_stall)
		else $error("item accepted with full pipeline");
`endif

endmodule

### tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dtvg_pkg::*;

	localparam int     CYCLE_LIMIT = 400000;
	localparam longint SAT_HI      = 64'sh7FFFFFFF;
	localparam longint SAT_LO      = -64'sh80000000;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  item_valid   = 1'b0;
	logic                  item_stall;
	item_t                 item         = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_t               result;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	// mirror of the block's registers and per-vector state
	strategy_t          cur_strategy  = STRAT_RAND1_BIN;
	logic [SCALE_W-1:0] cur_scale_f   = SCALE_F_RST;
	logic [SCALE_W-1:0] cur_scale_k   = SCALE_K_RST;
	logic [THR_W-1:0]   cur_threshold = THR_RST;
	logic               exp_on        = 1'b0;
	logic [COUNT_W-1:0] hit_tally     = '0;
	logic [COUNT_W-1:0] gene_count    = '0;

	result_t trial_q [$];
	int      mismatches    = 0;
	int      cycle_count   = 0;
	int      send_gap_pct  = 15;
	int      stall_gap_pct = 15;
	bit      quiet         = 1'b0;

	de_trial_vector_generator_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** de_trial_vector_generator_top: FAILED **");
			$finish;
		end
	end

	function automatic result_t predict_trial(item_t g);
		result_t            r;
		longint             tgt;
		longint             diff;
		longint             mutv;
		logic               coin;
		logic               use_m;
		logic               counted;
		logic [COUNT_W-1:0] cnt;
		tgt  = longint'($signed(g.target_gene));
		coin = {1'b0, g.random_draw} < cur_threshold;
		if (g.first_gene) begin
			exp_on     = 1'b0;
			hit_tally  = 9'd1;
			gene_count = '0;
		end
		diff = ((longint'($signed(g.donor_one)) - longint'($signed(g.donor_two)))
			* longint'(cur_scale_f)) >>> 16;
		if (cur_strategy == STRAT_CUR2RAND || cur_strategy == STRAT_CUR2RAND_BIN)
			mutv = tgt + (((longint'($signed(g.base_gene)) - tgt)
				* longint'(cur_scale_k)) >>> 16) + diff;
		else
			mutv = longint'($signed(g.base_gene)) + diff;
		if (mutv > SAT_HI)
			mutv = SAT_HI;
		else if (mutv < SAT_LO)
			mutv = SAT_LO;
		if (g.upper_enable && mutv > longint'($signed(g.upper_bound)))
			mutv = longint'($signed(g.upper_bound));
		if (g.lower_enable && mutv < longint'($signed(g.lower_bound)))
			mutv = longint'($signed(g.lower_bound));
		case (cur_strategy)
			STRAT_CUR2RAND: begin
				use_m   = 1'b1;
				counted = 1'b0;
			end
			STRAT_RAND1_EXP: begin
				if (coin)
					exp_on = 1'b1;
				counted = exp_on;
				use_m   = exp_on | g.first_gene;
			end
			default: begin
				counted = coin;
				use_m   = coin | g.first_gene;
			end
		endcase
		if (counted && hit_tally < COUNT_W'(MAX_GENES_DEF + 1))
			hit_tally++;
		if (gene_count < COUNT_W'(MAX_GENES_DEF))
			gene_count++;
		cnt = (cur_strategy == STRAT_CUR2RAND) ? gene_count : hit_tally;
		r.trial_value    = use_m ? mutv[31:0] : g.target_gene;
		r.took_mutant    = use_m;
		r.mutation_count = g.last_gene ? cnt : '0;
		r.vector_done    = g.last_gene;
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall)
			trial_q.push_back(predict_trial(item));
	end

	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_STRATEGY:  cur_strategy  = strategy_t'(cfg_data[1:0]);
				REG_SCALE_F:   cur_scale_f   = cfg_data[SCALE_W-1:0];
				REG_SCALE_K:   cur_scale_k   = cfg_data[SCALE_W-1:0];
				REG_THRESHOLD: cur_threshold = cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	task automatic report_mismatch(string what, logic signed [63:0] got,
		logic signed [63:0] want);
		if (mismatches < 100)
			$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (trial_q.size() == 0) begin
				report_mismatch("unexpected transaction", result.trial_value, 0);
			end else begin
				want = trial_q.pop_front();
				if (result.trial_value !== want.trial_value)
					report_mismatch("trial_value", result.trial_value, want.trial_value);
				if (result.took_mutant !== want.took_mutant)
					report_mismatch("took_mutant", result.took_mutant, want.took_mutant);
				if (result.mutation_count !== want.mutation_count)
					report_mismatch("mutation_count", result.mutation_count,
						want.mutation_count);
				if (result.vector_done !== want.vector_done)
					report_mismatch("vector_done", result.vector_done, want.vector_done);
			end
		end
	end

	always begin
		@(posedge clk);
		if (!quiet && $urandom_range(0, 99) < stall_gap_pct) begin
			result_stall <= 1'b1;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		result_stall <= 1'b0;
	end

	function automatic logic signed [31:0] pick_q16();
		int v;
		case ($urandom_range(0, 7))
			0: v = 32'sh7FFFFFFF;
			1: v = 32'sh80000000;
			2: v = 0;
			3, 4: v = int'($urandom_range(0, 1310720)) - 655360;
			default: v = $urandom();
		endcase
		return v;
	endfunction

	function automatic item_t make_gene(bit first, bit last);
		item_t g;
		g.target_gene  = pick_q16();
		g.donor_one    = pick_q16();
		g.donor_two    = pick_q16();
		g.base_gene    = pick_q16();
		g.upper_bound  = pick_q16();
		g.lower_bound  = pick_q16();
		g.upper_enable = 1'($urandom_range(0, 1));
		g.lower_enable = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 7))
			0: g.random_draw = '0;
			1: g.random_draw = 16'hFFFF;
			default: g.random_draw = DRAW_W'($urandom());
		endcase
		g.first_gene = first;
		g.last_gene  = last;
		return g;
	endfunction

	function automatic logic [SCALE_W-1:0] pick_scale();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return 18'h3FFFF;
			2: return 18'd65536;
			default: return SCALE_W'($urandom_range(0, 262143));
		endcase
	endfunction

	function automatic logic [THR_W-1:0] pick_threshold();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 17'd65535;
			2: return 17'd65536;
			3: return 17'h1FFFF;
			default: return THR_W'($urandom_range(0, 65536));
		endcase
	endfunction

	task automatic push_gene(item_t g);
		if (!quiet && $urandom_range(0, 99) < send_gap_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= g;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (trial_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_config(strategy_t s, logic [SCALE_W-1:0] f, logic [SCALE_W-1:0] k,
		logic [THR_W-1:0] thr);
		logic [CFG_DATA_W-1:0] vals [4];
		cfg_reg_t              regs [4];
		settle();
		regs = '{REG_STRATEGY, REG_SCALE_F, REG_SCALE_K, REG_THRESHOLD};
		vals = '{CFG_DATA_W'(s), f, k, CFG_DATA_W'(thr)};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic random_config();
		int pcts [4];
		pcts = '{0, 5, 20, 40};
		load_config(strategy_t'($urandom_range(0, 3)), pick_scale(), pick_scale(),
			pick_threshold());
		send_gap_pct  = pcts[$urandom_range(0, 3)];
		stall_gap_pct = pcts[$urandom_range(0, 3)];
	endtask

	// tallies start from zero when no start gene has been seen
	task automatic test_headless_genes();
		push_gene(make_gene(1'b0, 1'b0));
		push_gene(make_gene(1'b0, 1'b1));
	endtask

	task automatic test_field_extremes();
		item_t g;
		load_config(STRAT_CUR2RAND_BIN, 18'h3FFFF, 18'h3FFFF, 17'd65536);
		g = make_gene(1'b1, 1'b0);
		g.target_gene  = 32'sh7FFFFFFF;
		g.donor_one    = 32'sh7FFFFFFF;
		g.donor_two    = 32'sh80000000;
		g.base_gene    = 32'sh7FFFFFFF;
		g.upper_enable = 1'b0;
		g.lower_enable = 1'b0;
		push_gene(g);
		g = make_gene(1'b0, 1'b0);
		g.target_gene  = 32'sh80000000;
		g.donor_one    = 32'sh80000000;
		g.donor_two    = 32'sh7FFFFFFF;
		g.base_gene    = 32'sh80000000;
		g.upper_enable = 1'b0;
		g.lower_enable = 1'b0;
		g.random_draw  = 16'hFFFF;
		push_gene(g);
		// crossed bounds: lower wins
		g = make_gene(1'b0, 1'b0);
		g.upper_bound  = -32'sd655360;
		g.lower_bound  = 32'sd655360;
		g.upper_enable = 1'b1;
		g.lower_enable = 1'b1;
		g.random_draw  = '0;
		push_gene(g);
		g = '0;
		g.upper_enable = 1'b1;
		g.lower_enable = 1'b1;
		g.last_gene    = 1'b1;
		push_gene(g);
		load_config(STRAT_RAND1_BIN, '0, '0, THR_RST);
		push_gene(make_gene(1'b1, 1'b0));
		push_gene(make_gene(1'b0, 1'b1));
	endtask

	task automatic test_strategy_coins();
		strategy_t   s;
		item_t       g;
		logic [15:0] draws [4];
		draws = '{16'hFFFF, 16'd32767, 16'd32768, 16'd0};
		s = STRAT_RAND1_BIN;
		repeat (4) begin
			load_config(s, 18'd49152, 18'd16384, 17'd32768);
			for (int i = 0; i < 4; i++) begin
				g = make_gene(i == 0, i == 3);
				g.random_draw = draws[i];
				push_gene(g);
			end
			s = s.next();
		end
	endtask

	task automatic test_threshold_limits();
		item_t g;
		load_config(STRAT_RAND1_BIN, SCALE_F_RST, SCALE_K_RST, '0);
		g = make_gene(1'b1, 1'b0);
		g.random_draw = '0;
		push_gene(g);
		push_gene(make_gene(1'b0, 1'b1));
		load_config(STRAT_RAND1_BIN, SCALE_F_RST, SCALE_K_RST, 17'h1FFFF);
		push_gene(make_gene(1'b1, 1'b0));
		g = make_gene(1'b0, 1'b1);
		g.random_draw = 16'hFFFF;
		push_gene(g);
	endtask

	task automatic test_mid_vector_switch();
		item_t g;
		load_config(STRAT_RAND1_EXP, SCALE_F_RST, SCALE_K_RST, 17'd32768);
		g = make_gene(1'b1, 1'b0);
		g.random_draw = 16'hFFFF;
		push_gene(g);
		g = make_gene(1'b0, 1'b0);
		g.random_draw = 16'd100;
		push_gene(g);
		load_config(STRAT_RAND1_BIN, SCALE_F_RST, SCALE_K_RST, 17'd32768);
		g = make_gene(1'b0, 1'b0);
		g.random_draw = 16'hFFFF;
		push_gene(g);
		load_config(STRAT_CUR2RAND, SCALE_F_RST, SCALE_K_RST, 17'd32768);
		push_gene(make_gene(1'b0, 1'b1));
	endtask

	// both tallies run into saturation, then continue past a last gene
	task automatic test_overlong_vector();
		load_config(STRAT_RAND1_BIN, SCALE_F_RST, SCALE_K_RST, 17'h1FFFF);
		send_gap_pct  = 5;
		stall_gap_pct = 5;
		for (int i = 0; i < 265; i++)
			push_gene(make_gene(i == 0, 1'b0));
		load_config(STRAT_CUR2RAND, SCALE_F_RST, SCALE_K_RST, 17'h1FFFF);
		push_gene(make_gene(1'b0, 1'b1));
		load_config(STRAT_RAND1_BIN, SCALE_F_RST, SCALE_K_RST, 17'h1FFFF);
		push_gene(make_gene(1'b0, 1'b1));
	endtask

	task automatic test_random_vectors(int target);
		int sent;
		int len;
		int kind;
		sent = 0;
		while (sent < target) begin
			if (sent == 0 || $urandom_range(0, 5) == 0)
				random_config();
			len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			kind = $urandom_range(0, 9);
			for (int i = 0; i < len; i++) begin
				case (kind)
					0: push_gene(make_gene(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
					1: push_gene(make_gene(i == 0, 1'b0));
					2: push_gene(make_gene(1'b0, i == len - 1));
					default: push_gene(make_gene(i == 0, i == len - 1));
				endcase
			end
			sent += len;
		end
	endtask

	task automatic test_quiet_tail();
		int len;
		random_config();
		quiet = 1'b1;
		repeat (5) begin
			len = $urandom_range(4, 10);
			for (int i = 0; i < len; i++)
				push_gene(make_gene(i == 0, i == len - 1));
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_headless_genes();
		test_field_extremes();
		test_strategy_coins();
		test_threshold_limits();
		test_mid_vector_switch();
		test_overlong_vector();
		test_random_vectors(200);
		test_quiet_tail();
		item_valid <= 1'b0;
		@(posedge clk);
		while (trial_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("** de_trial_vector_generator_top: PASSED **");
		else
			$display("** de_trial_vector_generator_top: FAILED **");
		$finish;
	end

endmodule
